// ===== src/pointer_range_scanner_core_defines.svh =====
// assertion macros used by the prs_chk checker
`ifndef POINTER_RANGE_SCANNER_CORE_DEFINES_SVH
`define POINTER_RANGE_SCANNER_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define PRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prs check failed");

// next-cycle implication
`define PRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prs check failed");

`endif

// ===== src/prs_pkg.sv =====
package prs_pkg;

  localparam int WORD_W       = 64;
  localparam int OFFSET_W     = 32;
  localparam int TCOUNT_W     = 5;
  localparam int TINDEX_W     = 4;
  localparam int BYTE_W       = 8;
  localparam int SEEN_W       = 4;
  localparam int DELTA_W      = 33;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 64;
  localparam int S_TDATA_W    = 80;
  localparam int S_TUSER_W    = 2;
  localparam int M_TDATA_W    = 232;
  localparam int NUM_TARGETS_DEF = 16;

  localparam logic [SEEN_W-1:0] WINDOW_BYTES = SEEN_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS = 2'd0,
    REG_MAX_DIST     = 2'd1,
    REG_TARGET_COUNT = 2'd2
  } cfg_reg_t;

  localparam logic REQ_DATA   = 1'b0;
  localparam logic REQ_TARGET = 1'b1;

  // one window check as it walks down the row of cells
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] best;
    logic [WORD_W-1:0] addr;
  } cand_t;

endpackage

// ===== src/prs_cell.sv =====
module prs_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic [prs_pkg::TCOUNT_W-1:0]  target_count,
  input  logic                          wr_req,
  input  logic [prs_pkg::TINDEX_W-1:0]  wr_index,
  input  logic [prs_pkg::WORD_W-1:0]    wr_value,
  input  prs_pkg::cand_t                cin,
  output prs_pkg::cand_t                cout
);
  import prs_pkg::*;

  logic [WORD_W-1:0] target;
  logic              active;
  logic              hit;
  cand_t             cnext;

  assign active = int'(target_count) > IDX;
  assign hit = active && cin.valid && (target >= cin.lo) && (target <= cin.hi) &&
               (!cin.found || (target < cin.best));

  always_comb begin
    cnext       = cin;
    cnext.found = cin.found | hit;
    cnext.best  = hit ? target : cin.best;
  end

  always_ff @(posedge clk) begin
    if (wr_req && (int'(wr_index) == IDX)) begin
      target <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout.valid <= 1'b0;
    end else if (adv) begin
      cout <= cnext;
    end
  end

endmodule

// ===== src/pointer_range_scanner_core.sv =====
// pointer range scanner
// s_* carries one item per handshake: a byte of a memory dump, or a write of
// one target table slot (s_tuser[0] set). s_tuser[1] marks the first byte of
// a new buffer and restarts the 8-byte window. Once eight bytes of a buffer
// have arrived, each byte forms a little-endian window value v that is checked
// against the targets in use; the smallest target within the maximum distance
// of v comes out on m_* with the window address, v, the target and target - v.
// Configuration (base address, maximum distance, target count) goes through
// the cfg_* write port; the user must write it only while the block is idle,
// which the block itself does not enforce. Each target slot lives in one cell
// of a row of NUM_TARGETS cells; a window check walks one cell per cycle while
// the row is not frozen, and a byte with a full window holds s_tready low until
// its check leaves the last cell. Target writes and bytes of a short window do
// not hold s_tready low.
// A finished result waits in the output register while m_tready is low; the
// row of cells freezes only if a second result then reaches its end.
// rst clears configuration, window and handshake state; the target table is
// undefined until written.
module pointer_range_scanner_core #(
  parameter int NUM_TARGETS = prs_pkg::NUM_TARGETS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // data_byte[7:0], target_index[11:8], target_value[75:12], zero pad
  input  logic [prs_pkg::S_TDATA_W-1:0]   s_tdata,
  // req_type[0], first_byte[1]
  input  logic [prs_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // hit_address[63:0], hit_value[127:64], hit_target[191:128],
  // hit_delta[224:192], zero pad
  output logic [prs_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                            cfg_we,
  input  logic [prs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [prs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import prs_pkg::*;

  // configuration
  logic [WORD_W-1:0]   base_address;
  logic [OFFSET_W-1:0] max_dist;
  logic [TCOUNT_W-1:0] target_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      max_dist     <= '0;
      target_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BASE_ADDRESS: base_address <= cfg_data[WORD_W-1:0];
        REG_MAX_DIST:     max_dist     <= cfg_data[OFFSET_W-1:0];
        REG_TARGET_COUNT: target_count <= cfg_data[TCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic                req_type;
  logic                first_byte;
  logic [BYTE_W-1:0]   data_byte;
  logic [TINDEX_W-1:0] target_index;
  logic [WORD_W-1:0]   target_value;

  assign req_type     = s_tuser[0];
  assign first_byte   = s_tuser[1];
  assign data_byte    = s_tdata[7:0];
  assign target_index = s_tdata[11:8];
  assign target_value = s_tdata[75:12];

  logic busy;
  logic accept;
  logic data_acc;
  logic tgt_acc;
  logic adv;

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign data_acc = accept && (req_type == REQ_DATA);
  assign tgt_acc  = accept && (req_type == REQ_TARGET);

  // sliding window front end
  logic [WORD_W-1:0] window_bytes;
  logic [SEEN_W-1:0] bytes_seen;
  logic [WORD_W-1:0] window_offset;

  logic [WORD_W-1:0] wb_base, wb_next;
  logic [SEEN_W-1:0] seen_base, bytes_seen_next;
  logic [WORD_W-1:0] off_base, window_offset_next;
  logic              full;
  logic [WORD_W:0]   lo_diff, hi_sum;
  cand_t             launch;

  always_comb begin
    wb_base   = first_byte ? '0 : window_bytes;
    seen_base = first_byte ? '0 : bytes_seen;
    off_base  = first_byte ? '0 : window_offset;
    wb_next   = {data_byte, wb_base[WORD_W-1:BYTE_W]};
    if (seen_base >= WINDOW_BYTES) begin
      bytes_seen_next    = seen_base;
      window_offset_next = off_base + WORD_W'(1);
    end else begin
      bytes_seen_next    = seen_base + SEEN_W'(1);
      window_offset_next = off_base;
    end
    full = bytes_seen_next >= WINDOW_BYTES;

    // lower bound clamps at zero, upper bound saturates
    lo_diff = {1'b0, wb_next} - {{(WORD_W + 1 - OFFSET_W){1'b0}}, max_dist};
    hi_sum  = {1'b0, wb_next} + {{(WORD_W + 1 - OFFSET_W){1'b0}}, max_dist};

    launch.valid = data_acc && full;
    launch.found = 1'b0;
    launch.value = wb_next;
    launch.lo    = lo_diff[WORD_W] ? '0 : lo_diff[WORD_W-1:0];
    launch.hi    = hi_sum[WORD_W] ? '1 : hi_sum[WORD_W-1:0];
    launch.best  = '0;
    launch.addr  = base_address + window_offset_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bytes  <= '0;
      bytes_seen    <= '0;
      window_offset <= '0;
    end else if (data_acc) begin
      window_bytes  <= wb_next;
      bytes_seen    <= bytes_seen_next;
      window_offset <= window_offset_next;
    end
  end

  // row of cells, one target slot each
  cand_t head;
  cand_t chain [NUM_TARGETS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (adv) begin
      head <= launch;
    end
  end

  assign chain[0] = head;

  for (genvar i = 0; i < NUM_TARGETS; i++) begin : g_cell
    prs_cell #(
      .IDX (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .adv          (adv),
      .target_count (target_count),
      .wr_req       (tgt_acc),
      .wr_index     (target_index),
      .wr_value     (target_value),
      .cin          (chain[i]),
      .cout         (chain[i+1])
    );
  end

  cand_t tail;
  logic  load_out;

  assign tail     = chain[NUM_TARGETS];
  // hold the row only when a hit arrives while the output is still occupied and m_tready is low
  assign adv      = !(tail.valid && tail.found && m_tvalid && !m_tready);
  assign load_out = adv && tail.valid && tail.found;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (data_acc && full) begin
      busy <= 1'b1;
    end else if (tail.valid && adv) begin
      busy <= 1'b0;
    end
  end

  // output register
  logic [WORD_W-1:0]  hit_address, hit_value, hit_target, delta_full;
  logic [DELTA_W-1:0] hit_delta;

  assign delta_full = tail.best - tail.value;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load_out) begin
      hit_address <= tail.addr;
      hit_value   <= tail.value;
      hit_target  <= tail.best;
      hit_delta   <= delta_full[DELTA_W-1:0];
    end
  end

  assign m_tdata = {{(M_TDATA_W - 3*WORD_W - DELTA_W){1'b0}},
                    hit_delta, hit_target, hit_value, hit_address};

endmodule

// ===== src/prs_chk.sv =====
`include "pointer_range_scanner_core_defines.svh"

module prs_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [prs_pkg::S_TUSER_W-1:0]  s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [prs_pkg::M_TDATA_W-1:0]  m_tdata
);
  import prs_pkg::*;

  `PRS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  `PRS_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
  // a table write never occupies the row of cells
  `PRS_ASSERT_NEXT(a_tgt_no_stall, s_tvalid && s_tready && s_tuser[0] == REQ_TARGET,
                   s_tready)
  // delta is target minus value in 33 bits
  `PRS_ASSERT_NOW(a_delta, m_tvalid,
                  m_tdata[224:192] == DELTA_W'(m_tdata[191:128] - m_tdata[127:64]))

endmodule

bind pointer_range_scanner_core prs_chk u_prs_chk (.*);

// ===== tb/pointer_range_scanner_core_tb.sv =====
`timescale 1ns / 100ps

module pointer_range_scanner_core_tb;
  import prs_pkg::*;

  localparam int NUM_TARGETS = NUM_TARGETS_DEF;
  localparam int SETTLE_CYCLES = 2 * NUM_TARGETS + 8;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 128;
  localparam int NUM_PHASES = 8;
  localparam realtime RUN_LIMIT = 2_000_000;

  typedef struct packed {
    logic        req;
    logic [7:0]  dbyte;
    logic        first;
    logic [3:0]  slot;
    logic [63:0] tval;
  } scan_item_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [63:0] value;
    logic [63:0] target;
    logic [32:0] delta;
  } hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state, advanced on every accepted item
  logic [63:0] cfg_base = '0;
  logic [31:0] cfg_maxoff = '0;
  logic [4:0] cfg_count = '0;
  logic [63:0] win_q = '0;
  int unsigned win_fill = 0;
  logic [63:0] win_off = '0;
  logic [63:0] tgt_tbl [NUM_TARGETS];

  // table contents as the stimulus will have written them, in queue order
  logic [63:0] plan_tbl [NUM_TARGETS];

  scan_item_t feed_q [$];
  scan_item_t cur = '0;
  hit_t hits_due [$];
  int unsigned mism = 0;

  logic steady = 1'b0;
  logic hold_go = 1'b0;
  logic hold_taken = 1'b0;
  int unsigned hold_left = 0;

  pointer_range_scanner_core #(.NUM_TARGETS(NUM_TARGETS)) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit idle_roll();
    return !steady && ($urandom_range(99) < 12);
  endfunction

  function automatic void predict_hit(scan_item_t it);
    logic [63:0] v, lo, hi, best;
    logic found;
    int n;
    hit_t h;
    if (it.req == REQ_TARGET) begin
      tgt_tbl[it.slot] = it.tval;
      return;
    end
    if (it.first) begin
      win_q = '0;
      win_fill = 0;
      win_off = '0;
    end
    win_q = {it.dbyte, win_q[63:8]};
    if (win_fill >= 8) win_off = win_off + 64'd1;
    else win_fill++;
    if (win_fill < 8) return;

    v = win_q;
    lo = (v >= {32'h0, cfg_maxoff}) ? v - {32'h0, cfg_maxoff} : '0;
    hi = (v > ~64'h0 - {32'h0, cfg_maxoff}) ? ~64'h0 : v + {32'h0, cfg_maxoff};
    n = (cfg_count > NUM_TARGETS) ? NUM_TARGETS : int'(cfg_count);
    found = 1'b0;
    best = '0;
    for (int i = 0; i < n; i++) begin
      if (tgt_tbl[i] >= lo && tgt_tbl[i] <= hi && (!found || tgt_tbl[i] < best)) begin
        best = tgt_tbl[i];
        found = 1'b1;
      end
    end
    if (!found) return;
    h.addr = cfg_base + win_off;
    h.value = v;
    h.target = best;
    h.delta = 33'(best - v);
    hits_due.insert(hits_due.size(), h);
  endfunction

  // sender
  always @(posedge clk) begin : feed_drv
    scan_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_hit(cur);
      if (!s_tvalid || s_tready) begin
        if (feed_q.size() != 0 && !idle_roll()) begin
          nxt = feed_q.pop_front();
          cur <= nxt;
          s_tvalid <= 1'b1;
          s_tdata <= {4'b0, nxt.tval, nxt.slot, nxt.dbyte};
          s_tuser <= {nxt.first, nxt.req};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off that backs the block up
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !idle_roll();
    end
  end

  always @(posedge clk) begin : hit_mon
    hit_t want;
    hit_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.addr = m_tdata[63:0];
      got.value = m_tdata[127:64];
      got.target = m_tdata[191:128];
      got.delta = m_tdata[224:192];
      if (hits_due.size() == 0) begin
        if (mism < 10)
          $display("unexpected hit: addr %h value %h target %h delta %h",
                   got.addr, got.value, got.target, got.delta);
        mism++;
      end else begin
        want = hits_due.pop_front();
        if (got.addr !== want.addr || got.value !== want.value ||
            got.target !== want.target || got.delta !== want.delta) begin
          if (mism < 10)
            $display("hit mismatch: got %h %h %h %h want %h %h %h %h",
                     got.addr, got.value, got.target, got.delta,
                     want.addr, want.value, want.target, want.delta);
          mism++;
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BASE_ADDRESS: cfg_base = value;
      REG_MAX_DIST: cfg_maxoff = value[31:0];
      REG_TARGET_COUNT: cfg_count = value[4:0];
      default: ;
    endcase
  endtask

  // all items taken, all hits out, then let a window check drain
  // (sampled at the falling edge, once the sender's updates have landed)
  task automatic settle();
    while (feed_q.size() != 0 || s_tvalid || hits_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_target();
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return {32'h0000_7f3a, 24'h0, 8'($urandom)};  // dense cluster
      2: return {56'hffff_ffff_ffff_ff, 8'($urandom)};  // near the top
      default: return {32'h0000_7f3a, $urandom};
    endcase
  endfunction

  function automatic void push_target(logic [3:0] slot, logic [63:0] value);
    scan_item_t it;
    it.req = REQ_TARGET;
    it.dbyte = 8'($urandom);
    it.first = 1'($urandom);
    it.slot = slot;
    it.tval = value;
    plan_tbl[slot] = value;
    feed_q.insert(feed_q.size(), it);
  endfunction

  function automatic void push_byte(logic [7:0] b, logic first);
    scan_item_t it;
    it.req = REQ_DATA;
    it.dbyte = b;
    it.first = first;
    it.slot = 4'($urandom);
    it.tval = {$urandom, $urandom};
    feed_q.insert(feed_q.size(), it);
  endfunction

  // one buffer, optionally seeded with pointers near the targets in use
  function automatic void push_buffer(int len, bit plant);
    logic [7:0] dump [64];
    logic [63:0] t, d, v;
    int span;
    for (int i = 0; i < len; i++) dump[i] = 8'($urandom);
    span = (cfg_count > NUM_TARGETS) ? NUM_TARGETS : int'(cfg_count);
    if (span == 0) span = 1;
    for (int p = 0; p + 8 <= len; p++) begin
      if (plant && $urandom_range(99) < 25) begin
        t = plan_tbl[$urandom_range(span - 1)];
        case ($urandom_range(3))
          0: d = {32'h0, $urandom} % ({32'h0, cfg_maxoff} + 64'd1);
          1: d = {32'h0, cfg_maxoff};
          2: d = {32'h0, cfg_maxoff} + 64'd1;  // just out of range
          default: d = '0;
        endcase
        v = $urandom_range(1) ? t + d : t - d;
        for (int k = 0; k < 8; k++) dump[p + k] = v[8 * k +: 8];
      end
    end
    for (int i = 0; i < len; i++) push_byte(dump[i], i == 0);
  endfunction

  function automatic void build_phase(int n, bit fresh);
    int left, len, pick;
    left = n;
    if (fresh)
      for (int k = 0; k < NUM_TARGETS; k++) push_target(4'(k), pick_target());
    while (left > 0) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 28);
        push_buffer(len, 1'b1);
        left -= len;
      end else if (pick < 80) begin
        push_target(4'($urandom), pick_target());
        left--;
      end else if (pick < 90) begin
        // bytes that carry on the current buffer
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) push_byte(8'($urandom), 1'b0);
        left -= len;
      end else begin
        len = $urandom_range(8, 40);
        push_buffer(len, 1'b0);
        left -= len;
      end
    end
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, data before any buffer start, short buffer,
    // address wrap past the top
    write_reg(REG_BASE_ADDRESS, 64'hffff_ffff_ffff_fffe);
    write_reg(REG_MAX_DIST, 64'hffff_ffff);
    write_reg(REG_TARGET_COUNT, 64'd2);
    push_target(4'd0, 64'h0);
    push_target(4'd1, ~64'h0);
    push_target(4'd15, pick_target());
    for (int i = 0; i < 8; i++) push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b0);
    for (int i = 0; i < 5; i++) push_byte(8'($urandom), i == 0);
    for (int i = 0; i < 10; i++) push_byte(8'h00, i == 0);
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_BASE_ADDRESS, {$urandom, $urandom});
          write_reg(REG_MAX_DIST, 64'd0);
          write_reg(REG_TARGET_COUNT, 64'd16);
        end
        1: begin
          write_reg(REG_BASE_ADDRESS, 64'hffff_ffff_ffff_fff0);
          write_reg(REG_MAX_DIST, 64'hffff_ffff);
          write_reg(REG_TARGET_COUNT, 64'd31);
        end
        2: begin
          write_reg(REG_BASE_ADDRESS, {$urandom, $urandom});
          write_reg(REG_MAX_DIST, {32'h0, $urandom});
          write_reg(REG_TARGET_COUNT, 64'd0);
        end
        3: begin
          write_reg(REG_BASE_ADDRESS, {$urandom, $urandom});
          write_reg(REG_MAX_DIST, 64'($urandom_range(255)));
          write_reg(REG_TARGET_COUNT, 64'd1);
        end
        4: begin
          write_reg(REG_BASE_ADDRESS, {$urandom, $urandom});
          write_reg(REG_MAX_DIST, {32'h0, $urandom});
          write_reg(REG_TARGET_COUNT, 64'd17);
          steady <= 1'b1;
        end
        5: begin
          write_reg(REG_BASE_ADDRESS, {$urandom, $urandom});
          write_reg(REG_MAX_DIST, 64'hffff_ffff);
          write_reg(REG_TARGET_COUNT, 64'($urandom_range(1, NUM_TARGETS)));
          hold_go <= 1'b1;
        end
        6: begin
          write_reg(REG_BASE_ADDRESS, 64'h0);
          write_reg(REG_MAX_DIST, 64'($urandom_range(65535)));
          write_reg(REG_TARGET_COUNT, 64'd16);
        end
        default: begin
          write_reg(REG_BASE_ADDRESS, {$urandom, $urandom});
          write_reg(REG_MAX_DIST, {32'h0, $urandom});
          write_reg(REG_TARGET_COUNT, 64'($urandom_range(31)));
        end
      endcase
      build_phase(PHASE_ITEMS, ph == 0);
      settle();
      steady <= 1'b0;
    end

    if (hits_due.size() != 0) $display("%0d hits never came out", hits_due.size());
    if (mism == 0 && hits_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
